/* rtl/vnorm_pkg.sv */
// vnorm_pkg: shared constants and types for the vector normalizer
// used by vector3_normalize and vnorm_checker under rtl/, no dependencies of its own
package vnorm_pkg;

   localparam int COMPONENT_WIDTH = 32;
   localparam int LANES           = 3;
   localparam int UNIT_WIDTH      = 32;
   localparam int MAG_WIDTH       = 32;
   // quotient bits of sq/s scaled by 2^60: one integer bit and 60 fraction bits
   localparam int QUOT_BITS       = 61;

   // flags that ride alongside the arithmetic pipeline
   typedef struct packed {
      logic             zero;
      logic [LANES-1:0] neg;
   } side_type;

endpackage

/* rtl/vnorm_delay.sv */
// vnorm_delay: enable-gated register delay line without reset
// depends on nothing
module vnorm_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

/* rtl/vnorm_lane.sv */
// vnorm_lane: absolute value and exact square of one component, three stages
// depends on nothing
module vnorm_lane #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [W-1:0]   comp,
   output logic [2*W-1:0]        sq,
   output logic                  neg
);

   localparam int LO = W / 2;
   localparam int HI = W - LO;

   logic [W-1:0]         comp_u;
   logic [W-1:0]         mag_ff;
   logic                 neg_a_ff;
   logic                 neg_b_ff;
   logic                 neg_c_ff;
   logic [2*LO-1:0]      ll_ff;
   logic [LO+HI-1:0]     lh_ff;
   logic [2*HI-1:0]      hh_ff;
   logic [LO-1:0]        lo;
   logic [HI-1:0]        hi;
   logic [2*W-1:0]       sq_in;
   logic [2*W-1:0]       sq_ff;

   assign comp_u = unsigned'(comp);
   assign lo     = mag_ff[LO-1:0];
   assign hi     = mag_ff[W-1:LO];

   // cross term appears twice, hence the extra shift by one
   assign sq_in = ((2*W)'(hh_ff) << (2*LO)) + ((2*W)'(lh_ff) << (LO+1))
                  + (2*W)'(ll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         // most negative value maps to 2^(W-1), which still fits W bits
         mag_ff   <= comp_u[W-1] ? (~comp_u + W'(1)) : comp_u;
         neg_a_ff <= comp_u[W-1];
         ll_ff    <= (2*LO)'(lo) * (2*LO)'(lo);
         lh_ff    <= (LO+HI)'(lo) * (LO+HI)'(hi);
         hh_ff    <= (2*HI)'(hi) * (2*HI)'(hi);
         neg_b_ff <= neg_a_ff;
         sq_ff    <= sq_in;
         neg_c_ff <= neg_b_ff;
      end
   end

   assign sq  = sq_ff;
   assign neg = neg_c_ff;

endmodule

/* rtl/vnorm_div_pipe.sv */
// vnorm_div_pipe: pipelined restoring divider, one quotient bit per stage
// depends on nothing; expects num <= den
module vnorm_div_pipe #(
   parameter int NW = 64,
   parameter int DW = 66,
   parameter int QB = 61
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QB-1:0] quo
);

   logic [DW-1:0] rem_ff [QB];
   logic [DW-1:0] den_ff [QB];
   logic [QB-1:0] q_ff   [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [DW:0]   sh;
      logic [DW:0]   den_x;
      logic [DW:0]   diff;
      logic [DW-1:0] den_p;
      logic [QB-1:0] q_p;
      logic          ge;

      if (k == 0) begin : g_first
         assign sh    = (DW+1)'(num);
         assign den_p = den;
         assign q_p   = '0;
      end else begin : g_next
         assign sh    = {rem_ff[k-1], 1'b0};
         assign den_p = den_ff[k-1];
         assign q_p   = q_ff[k-1];
      end

      assign den_x = {1'b0, den_p};
      assign ge    = (sh >= den_x);
      assign diff  = sh - den_x;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
            den_ff[k] <= den_p;
            q_ff[k]   <= {q_p[QB-2:0], ge};
         end
      end
   end

   assign quo = q_ff[QB-1];

endmodule

/* rtl/vnorm_sqrt_pipe.sv */
// vnorm_sqrt_pipe: pipelined digit-by-digit integer square root with remainder
// depends on nothing
module vnorm_sqrt_pipe #(
   parameter int IW = 62
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [IW-1:0]                 rad,
   output logic [(IW+(IW%2))/2-1:0]      root,
   output logic [(IW+(IW%2))/2+1:0]      rem
);

   localparam int PW = IW + (IW % 2);
   localparam int R  = PW / 2;
   localparam int RW = R + 2;

   logic [PW-1:0] rad_ff  [R];
   logic [RW-1:0] rem_ff  [R];
   logic [R-1:0]  root_ff [R];

   for (genvar k = 0; k < R; k++) begin : g_stage
      logic [PW-1:0] rad_p;
      logic [RW-1:0] rem_p;
      logic [R-1:0]  root_p;
      logic [RW+1:0] rem_sh;
      logic [RW+1:0] trial;
      logic [RW+1:0] diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign rad_p  = PW'(rad);
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign rad_p  = rad_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
      end

      assign rem_sh = {rem_p, rad_p[PW-1 -: 2]};
      assign trial  = (RW+2)'({root_p, 2'b01});
      assign ge     = (rem_sh >= trial);
      assign diff   = rem_sh - trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_p << 2;
            rem_ff[k]  <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
            root_ff[k] <= {root_p[R-2:0], ge};
         end
      end
   end

   assign root = root_ff[R-1];
   assign rem  = rem_ff[R-1];

endmodule

/* rtl/vector3_normalize.sv */
// vector3_normalize: fully pipelined; a request passes 4 front stages, 61 divider
// stages, 31 root stages and the output register; throughput one request per
// cycle unless stalled, set by the fully pipelined divider lanes
// the whole pipeline advances together and stalls only while a result waits
// synchronous active-high reset clears the valid pipeline; data regs keep junk
// depends on vnorm_pkg, vnorm_lane, vnorm_div_pipe, vnorm_sqrt_pipe, vnorm_delay
module vector3_normalize #(
   parameter int COMPONENT_WIDTH = vnorm_pkg::COMPONENT_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_x,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_y,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [vnorm_pkg::UNIT_WIDTH-1:0] rsp_unit_x,
   output logic signed [vnorm_pkg::UNIT_WIDTH-1:0] rsp_unit_y,
   output logic signed [vnorm_pkg::UNIT_WIDTH-1:0] rsp_unit_z,
   output logic [vnorm_pkg::MAG_WIDTH-1:0]       rsp_magnitude,
   output logic                                  rsp_zero_vector
);

   localparam int W        = COMPONENT_WIDTH;
   localparam int SQW      = 2 * W;
   localparam int SW       = 2 * W + 2;           // sum of three squares
   localparam int QB       = vnorm_pkg::QUOT_BITS;
   localparam int UW       = vnorm_pkg::UNIT_WIDTH;
   localparam int MW       = vnorm_pkg::MAG_WIDTH;
   localparam int NL       = vnorm_pkg::LANES;
   localparam int USQ_R    = (QB + (QB % 2)) / 2; // unit root bits and stages
   localparam int MSQ_R    = SW / 2;              // length root bits and stages
   localparam int MRW      = MSQ_R + 2;
   localparam int MRND     = MSQ_R + 1;           // rounded length width
   localparam int FRONT    = 4;                   // abs, products, square, sum
   localparam int SIDE_DLY = QB + USQ_R;
   localparam int MAG_DLY  = QB + USQ_R - MSQ_R - 1;
   localparam int TOTAL    = FRONT + QB + USQ_R + 1;
   localparam int SIDE_W   = $bits(vnorm_pkg::side_type);

   // global advance: everything moves unless a finished result is held
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // valid bits through the pipeline
   logic [TOTAL-1:0] valid_ff;
   logic [TOTAL-1:0] valid_in;
   assign valid_in = {valid_ff[TOTAL-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // per-component lanes: abs value and exact square
   logic signed [W-1:0] comp [NL];
   logic [SQW-1:0]      sq   [NL];
   logic [NL-1:0]       neg;

   assign comp[0] = req_x;
   assign comp[1] = req_y;
   assign comp[2] = req_z;

   for (genvar i = 0; i < NL; i++) begin : g_lane
      vnorm_lane #(.W(W)) u_lane (
         .clock (clock),
         .en    (en),
         .comp  (comp[i]),
         .sq    (sq[i]),
         .neg   (neg[i])
      );
   end

   // merge: sum of squares, squares held one stage to line up with it
   logic [SW-1:0]         s_in;
   logic [SW-1:0]         s_ff;
   logic [SQW-1:0]        sq_d_ff [NL];
   vnorm_pkg::side_type   side_in;
   vnorm_pkg::side_type   side_ff;
   vnorm_pkg::side_type   side_out;

   assign s_in         = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
   assign side_in.zero = (s_in == '0);
   assign side_in.neg  = neg;

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in;
         side_ff <= side_in;
         for (int i = 0; i < NL; i++) begin
            sq_d_ff[i] <= sq[i];
         end
      end
   end

   // side flags wait for the unit path
   logic [SIDE_W-1:0] side_dly;
   vnorm_delay #(.WIDTH(SIDE_W), .DEPTH(SIDE_DLY)) u_side_dly (
      .clock (clock),
      .en    (en),
      .din   (side_ff),
      .dout  (side_dly)
   );
   assign side_out = vnorm_pkg::side_type'(side_dly);

   // unit lanes: sq/s scaled by 2^60, then its square root gives Q2.30
   logic [QB-1:0]    quo   [NL];
   logic [USQ_R-1:0] uroot [NL];
   logic [USQ_R+1:0] urem  [NL];   // remainder of the unit root, not needed

   for (genvar i = 0; i < NL; i++) begin : g_unit
      vnorm_div_pipe #(.NW(SQW), .DW(SW), .QB(QB)) u_div (
         .clock (clock),
         .en    (en),
         .num   (sq_d_ff[i]),
         .den   (s_ff),
         .quo   (quo[i])
      );
      vnorm_sqrt_pipe #(.IW(QB)) u_usqrt (
         .clock (clock),
         .en    (en),
         .rad   (quo[i]),
         .root  (uroot[i]),
         .rem   (urem[i])
      );
   end

   // length: root of the sum, rounded to nearest, then saturated
   logic [MSQ_R-1:0] mroot;
   logic [MRW-1:0]   mrem;
   logic [MRND-1:0]  mrnd;
   logic [MW-1:0]    msat;
   logic [MW-1:0]    msat_ff;
   logic [MW-1:0]    mag_dly;

   vnorm_sqrt_pipe #(.IW(SW)) u_msqrt (
      .clock (clock),
      .en    (en),
      .rad   (s_ff),
      .root  (mroot),
      .rem   (mrem)
   );

   // remainder above the root means the true root is past the half point
   assign mrnd = MRND'(mroot) + MRND'(mrem > MRW'(mroot));

   if (MRND > MW) begin : g_sat
      assign msat = (|mrnd[MRND-1:MW]) ? '1 : mrnd[MW-1:0];
   end else begin : g_nosat
      assign msat = MW'(mrnd);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         msat_ff <= msat;
      end
   end

   vnorm_delay #(.WIDTH(MW), .DEPTH(MAG_DLY)) u_mag_dly (
      .clock (clock),
      .en    (en),
      .din   (msat_ff),
      .dout  (mag_dly)
   );

   // output register: apply signs, force zeros for the zero vector
   logic [UW-1:0] unit_in [NL];
   logic [UW-1:0] unit_ff [NL];
   logic [MW-1:0] mag_ff;
   logic          zero_ff;

   for (genvar i = 0; i < NL; i++) begin : g_sign
      logic [UW-1:0] u_ext;
      assign u_ext      = UW'(uroot[i]);
      assign unit_in[i] = side_out.zero ? '0 : (side_out.neg[i] ? (~u_ext + UW'(1)) : u_ext);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NL; i++) begin
            unit_ff[i] <= unit_in[i];
         end
         mag_ff  <= side_out.zero ? '0 : mag_dly;
         zero_ff <= side_out.zero;
      end
   end

   assign rsp_valid       = valid_ff[TOTAL-1];
   assign rsp_unit_x      = signed'(unit_ff[0]);
   assign rsp_unit_y      = signed'(unit_ff[1]);
   assign rsp_unit_z      = signed'(unit_ff[2]);
   assign rsp_magnitude   = mag_ff;
   assign rsp_zero_vector = zero_ff;

endmodule

/* rtl/vnorm_checker.sv */
// vnorm_checker: port-level assertions for vector3_normalize, bound to the top
// depends on vnorm_pkg and the top level's ports
module vnorm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [vnorm_pkg::UNIT_WIDTH-1:0] rsp_unit_x,
   input logic signed [vnorm_pkg::UNIT_WIDTH-1:0] rsp_unit_y,
   input logic signed [vnorm_pkg::UNIT_WIDTH-1:0] rsp_unit_z,
   input logic [vnorm_pkg::MAG_WIDTH-1:0]       rsp_magnitude,
   input logic                                  rsp_zero_vector
);

   localparam logic signed [vnorm_pkg::UNIT_WIDTH-1:0] ONE =
      vnorm_pkg::UNIT_WIDTH'(1) << 30;

   // zero vector gives an all-zero result
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |->
         rsp_unit_x == 0 && rsp_unit_y == 0 && rsp_unit_z == 0 && rsp_magnitude == 0)
      else $error("zero vector result not all zero");

   // unit components never exceed one in magnitude
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unit_x <= ONE && rsp_unit_x >= -ONE &&
                    rsp_unit_y <= ONE && rsp_unit_y >= -ONE &&
                    rsp_unit_z <= ONE && rsp_unit_z >= -ONE)
      else $error("unit component out of range");

   // request side stalls only while a result is held
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow result stall");

   // a held result stays put (unit_x, magnitude and zero flag are checked)
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unit_x) &&
         $stable(rsp_magnitude) && $stable(rsp_zero_vector))
      else $error("stalled result changed");

endmodule

bind vector3_normalize vnorm_checker u_vnorm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_unit_x      (rsp_unit_x),
   .rsp_unit_y      (rsp_unit_y),
   .rsp_unit_z      (rsp_unit_z),
   .rsp_magnitude   (rsp_magnitude),
   .rsp_zero_vector (rsp_zero_vector)
);

/* dv/vector3_normalize_tb.sv */
// vector3_normalize_tb: self-checking bench for the three-lane vector normalizer
// drives vectors over the request channel and checks unit vector, length and flag
// depends on rtl/vnorm_pkg.sv and rtl/vector3_normalize.sv
`timescale 1ns / 1ps

module vector3_normalize_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 150;   // longer than the request-to-result latency
   localparam int HOLD_CYCLES    = 400;   // long enough to fill the pipeline

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec_type;

   typedef struct {
      logic signed [31:0] unit_x;
      logic signed [31:0] unit_y;
      logic signed [31:0] unit_z;
      logic [31:0]        magnitude;
      logic               zero_vector;
   } norm_type;

   // idling styles, one per phase
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_x = '0, req_y = '0, req_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic [31:0] rsp_magnitude;
   logic rsp_zero_vector;

   vec_type       vector_q[$];   // vectors waiting to be driven
   norm_type      norm_q[$];     // predicted results, oldest first
   idle_mode_type idle_mode = IDLE_NONE;
   int         req_count = 0;
   int         rsp_count = 0;
   int         zero_count = 0;
   int         error_count = 0;
   int         hold_seq = 0;   // bumped to ask the receiver for a long hold-off
   int         hold_seen = 0;
   int         hold_left = 0;
   int         quiet_cycles = 0;

   always #5 clock = ~clock;

   vector3_normalize dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x(req_x), .req_y(req_y), .req_z(req_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y), .rsp_unit_z(rsp_unit_z),
      .rsp_magnitude(rsp_magnitude), .rsp_zero_vector(rsp_zero_vector)
   );

   // floor of the square root of a 128-bit value, one bit per pass
   function automatic logic [63:0] floor_root(logic [127:0] s);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      return r;
   endfunction

   // expected normalizer output for one vector
   function automatic norm_type normalize_vector(vec_type v);
      norm_type    n;
      logic [31:0] comp[3];
      logic [63:0] mag[3];
      logic [127:0] sq[3];
      logic [127:0] sum;
      logic [127:0] rem;
      logic [63:0] root;
      logic [63:0] u;
      logic [31:0] unit[3];
      comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
      for (int i = 0; i < 3; i++) begin
         // most negative value gives magnitude 2^31 exactly
         mag[i] = comp[i][31] ? 64'd0 - {{32{1'b1}}, comp[i]} : {32'd0, comp[i]};
         sq[i]  = {64'd0, mag[i]} * {64'd0, mag[i]};
      end
      n.zero_vector = (mag[0] == 0) && (mag[1] == 0) && (mag[2] == 0);
      if (n.zero_vector) begin
         n.unit_x = '0; n.unit_y = '0; n.unit_z = '0; n.magnitude = '0;
         return n;
      end
      sum  = sq[0] + sq[1] + sq[2];
      root = floor_root(sum);
      rem  = sum - {64'd0, root} * {64'd0, root};
      if (rem > {64'd0, root}) root = root + 1;   // round to nearest
      n.magnitude = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
      for (int i = 0; i < 3; i++) begin
         // unit = sqrt(sq / sum) in Q2.30, truncated
         u = floor_root((sq[i] << 60) / sum);
         unit[i] = comp[i][31] ? 32'd0 - u[31:0] : u[31:0];
      end
      n.unit_x = unit[0]; n.unit_y = unit[1]; n.unit_z = unit[2];
      return n;
   endfunction

   // driver: offers queued vectors, records a prediction on each accept
   always @(posedge clock) begin
      vec_type v;
      int   idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            v.x = req_x; v.y = req_y; v.z = req_z;
            norm_q.push_back(normalize_vector(v));
            req_count++;
         end
         if (!req_valid || req_ready) begin
            idle_pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 38 : 0;
            if (vector_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
               v = vector_q.pop_front();
               req_valid <= 1'b1;
               req_x <= v.x; req_y <= v.y; req_z <= v.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result against the oldest prediction
   always @(posedge clock) begin
      norm_type exp_n;
      int    stall_pct;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (norm_q.size() == 0) begin
               $display("%0t: unexpected result unit=(%h %h %h) mag=%h zero=%b", $time,
                        rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_magnitude, rsp_zero_vector);
               error_count++;
            end else begin
               exp_n = norm_q.pop_front();
               if (exp_n.zero_vector) zero_count++;
               if (rsp_unit_x !== exp_n.unit_x) begin
                  $display("%0t: unit_x expected %h got %h", $time, exp_n.unit_x, rsp_unit_x);
                  error_count++;
               end
               if (rsp_unit_y !== exp_n.unit_y) begin
                  $display("%0t: unit_y expected %h got %h", $time, exp_n.unit_y, rsp_unit_y);
                  error_count++;
               end
               if (rsp_unit_z !== exp_n.unit_z) begin
                  $display("%0t: unit_z expected %h got %h", $time, exp_n.unit_z, rsp_unit_z);
                  error_count++;
               end
               if (rsp_magnitude !== exp_n.magnitude) begin
                  $display("%0t: magnitude expected %h got %h", $time,
                           exp_n.magnitude, rsp_magnitude);
                  error_count++;
               end
               if (rsp_zero_vector !== exp_n.zero_vector) begin
                  $display("%0t: zero_vector expected %b got %b", $time,
                           exp_n.zero_vector, rsp_zero_vector);
                  error_count++;
               end
            end
         end
         // a long hold-off lets the pipeline fill and back-pressure the input
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 88 : (idle_mode == IDLE_BOTH) ? 38 : 0;
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog: cycles in which neither channel moves a request or result
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, norm_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] random_component();
      case ($urandom_range(5))
         0:       return '0;
         1:       return $signed($urandom_range(65535)) - 32768;   // around zero
         2:       return $urandom() >> $urandom_range(31);        // spread of scales
         3:       return $signed(32'h8000_0000);
         default: return $urandom();
      endcase
   endfunction

   task automatic add_vector(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      vec_type v;
      v.x = x; v.y = y; v.z = z;
      vector_q.push_back(v);
   endtask

   task automatic add_random(int count);
      for (int i = 0; i < count; i++)
         add_vector(random_component(), random_component(), random_component());
   endtask

   // sender holds back until every prediction has been matched
   task automatic wait_drained();
      while (vector_q.size() > 0 || req_valid || norm_q.size() > 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: zero vector, extremes, most negative, single axes, tiny values
      add_vector(0, 0, 0);
      add_vector(32'h0001_0000, 0, 0);
      add_vector(0, -32'sh0001_0000, 0);
      add_vector(0, 0, 32'h0001_0000);
      add_vector(1, 0, 0);
      add_vector(0, -1, 0);
      add_vector(0, 0, 1);
      add_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_vector(32'h8000_0000, 0, 0);
      add_vector(0, 32'h8000_0000, 0);
      add_vector(0, 0, 32'h8000_0000);
      add_vector(32'h7FFF_FFFF, 32'h8000_0000, 1);
      add_vector(-1, -1, -1);
      add_vector(1, 1, 1);
      add_vector(32'h0003_0000, 32'h0004_0000, 0);
      add_vector(-32'sh0003_0000, 0, 32'h0004_0000);
      add_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
      add_vector(32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_0001);
      add_vector(0, 0, 0);
      wait_drained();

      // receiver holds off while requests keep coming
      hold_seq++;
      add_random(200);
      wait_drained();

      idle_mode = IDLE_NONE;
      add_random(120);
      wait_drained();
      idle_mode = IDLE_SENDER;
      add_random(120);
      wait_drained();
      idle_mode = IDLE_RECEIVER;
      add_random(120);
      wait_drained();
      idle_mode = IDLE_BOTH;
      add_random(120);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d results checked (%0d zero vectors)",
               req_count, rsp_count, zero_count);
      $display("covered extremes, back-pressure and random idling on both channels");
      if (error_count == 0 && norm_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* vector3_normalize.f */
rtl/vnorm_pkg.sv
rtl/vnorm_delay.sv
rtl/vnorm_lane.sv
rtl/vnorm_div_pipe.sv
rtl/vnorm_sqrt_pipe.sv
rtl/vector3_normalize.sv
rtl/vnorm_checker.sv
dv/vector3_normalize_tb.sv
